FILE: rtl/cnra_pkg.sv
// shared types, constants and lookup tables for the ninth-root cyclotomic ring alu
// no dependencies; imported by every module of the block
package cnra_pkg;

	localparam int COEF_W     = 32;
	localparam int EXP_W      = 5;
	localparam int EXPI_W     = 6;
	localparam int EXP_MAX    = 31;
	localparam int WIDE_W     = 96;
	localparam int DIGIT_W    = 8;
	localparam int N_DIGITS   = WIDE_W / DIGIT_W;
	localparam int DCNT_W     = 4;
	localparam int LANES      = 6;
	localparam int LANE_W     = 3;
	localparam int MAC_STEPS  = 9;
	localparam int STEP_W     = 4;
	localparam int K_W        = 4;
	localparam int ZETA_ORD   = 9;
	localparam int DIV3_RECIP = 683;
	localparam int DIV3_SHIFT = 11;
	localparam int CUR_W      = DIGIT_W + 2;

	localparam logic [2:0] FN_LOAD = 3'd0;
	localparam logic [2:0] FN_ADD  = 3'd1;
	localparam logic [2:0] FN_SUB  = 3'd2;
	localparam logic [2:0] FN_MUL  = 3'd3;
	localparam logic [2:0] FN_GAL  = 3'd4;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t [LANES-1:0] coef_vec_t;

	typedef struct packed {
		logic [2:0]              func;
		logic signed [COEF_W-1:0] b_c0;
		logic signed [COEF_W-1:0] b_c1;
		logic signed [COEF_W-1:0] b_c2;
		logic signed [COEF_W-1:0] b_c3;
		logic signed [COEF_W-1:0] b_c4;
		logic signed [COEF_W-1:0] b_c5;
		logic [EXP_W-1:0]        b_exp;
		logic [K_W-1:0]          galois_k;
	} op_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] r_c0;
		logic signed [COEF_W-1:0] r_c1;
		logic signed [COEF_W-1:0] r_c2;
		logic signed [COEF_W-1:0] r_c3;
		logic signed [COEF_W-1:0] r_c4;
		logic signed [COEF_W-1:0] r_c5;
		logic [EXP_W-1:0]        r_exp;
		logic                    is_zero;
		logic                    overflow;
	} res_t;

	typedef enum logic [3:0] {
		L_HOLD,
		L_LOAD_B,
		L_LOAD_XY,
		L_X3,
		L_Y3,
		L_ADD,
		L_SUB,
		L_CLR,
		L_MAC,
		L_TO_MAG,
		L_DIV_INIT,
		L_DIV_STEP,
		L_DIV_TAKE
	} lane_op_t;

	typedef struct packed {
		lane_op_t           op;
		logic               galois;
		logic [STEP_W-1:0]  step;
		logic [K_W-1:0]     k;
	} lane_ctl_t;

	typedef struct packed {
		logic  rem_zero;
		logic  fits;
		coef_t coef;
	} lane_sts_t;

	typedef lane_sts_t [LANES-1:0] lane_sts_vec_t;

	typedef struct packed {
		logic all_rem_zero;
		logic all_fit;
	} merge_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BLOAD,
		ST_TOMAG,
		ST_CHECK,
		ST_DIV,
		ST_DIVCHK,
		ST_BSAVE,
		ST_DISPATCH,
		ST_ALIGN,
		ST_MAC,
		ST_DRAIN,
		ST_COMMIT
	} st_t;

	// product schedule: lane m sums products landing on zeta^m, minus those folded from zeta^(6+m%3)
	typedef struct packed {
		logic              valid;
		logic              neg;
		logic [LANE_W-1:0] ai;
		logic [LANE_W-1:0] bj;
	} sched_t;

	typedef sched_t [MAC_STEPS-1:0] sched_row_t;
	typedef sched_row_t [LANES-1:0] sched_tab_t;

	function automatic sched_tab_t build_mul_sched();
		sched_tab_t t;
		int cnt [LANES];
		int s;
		t = '0;
		for (int l = 0; l < LANES; l++) cnt[l] = 0;
		for (int i = 0; i < LANES; i++) begin
			for (int j = 0; j < LANES; j++) begin
				s = i + j;
				for (int l = 0; l < LANES; l++) begin
					if ((s % ZETA_ORD) == l) begin
						t[l][cnt[l]] = '{valid: 1'b1, neg: 1'b0,
							ai: LANE_W'(i), bj: LANE_W'(j)};
						cnt[l] = cnt[l] + 1;
					end
					if (s == LANES + (l % 3)) begin
						t[l][cnt[l]] = '{valid: 1'b1, neg: 1'b1,
							ai: LANE_W'(i), bj: LANE_W'(j)};
						cnt[l] = cnt[l] + 1;
					end
				end
			end
		end
		return t;
	endfunction

	localparam sched_tab_t MUL_SCHED = build_mul_sched();

	// galois map destination index (k*i) mod 9
	typedef logic [K_W-1:0] gdest_t;
	typedef gdest_t [LANES-1:0] grow_t;
	typedef grow_t [ZETA_ORD-1:0] gtab_t;

	function automatic gtab_t build_gal_dest();
		gtab_t t;
		t = '0;
		for (int k = 0; k < ZETA_ORD; k++) begin
			for (int i = 0; i < LANES; i++) t[k][i] = K_W'((k * i) % ZETA_ORD);
		end
		return t;
	endfunction

	localparam gtab_t GAL_DEST = build_gal_dest();

endpackage

FILE: rtl/cnra_lane.sv
// one coefficient lane: alignment by three, multiply-accumulate, magnitude and digit-serial divide by three
// depends on cnra_pkg
module cnra_lane import cnra_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [LANE_W-1:0] lane_idx,
	input  lane_ctl_t         ctl,
	input  coef_vec_t         acc,
	input  coef_vec_t         opnd,
	output lane_sts_t         sts
);

	logic signed [WIDE_W-1:0]   x_q;
	logic signed [WIDE_W-1:0]   y_q;
	logic [WIDE_W-1:0]          mag_q;
	logic [WIDE_W-1:0]          sh_q;
	logic [WIDE_W-1:0]          quo_q;
	logic                       sgn_q;
	logic [1:0]                 rem_q;
	logic signed [2*COEF_W-1:0] prod_s1;
	logic                       pv_s1;
	logic                       pn_s1;

	sched_t                     sc;
	logic                       gvalid;
	logic [LANE_W-1:0]          gi;
	logic [K_W-1:0]             gd;
	logic [K_W-1:0]             own_dest;
	logic [K_W-1:0]             fold_dest;
	coef_t                      mac_a;
	coef_t                      mac_b;
	logic                       mac_v;
	logic                       mac_n;
	logic [CUR_W-1:0]           cur;
	logic [2*CUR_W-1:0]         dprod;
	logic [DIGIT_W-1:0]         qd;
	logic [CUR_W-1:0]           rnew;
	logic [WIDE_W-1:0]          x_abs;
	logic signed [WIDE_W-1:0]   prod_ext;
	coef_t                      a_own;
	coef_t                      b_own;

	always_comb begin
		sc        = MUL_SCHED[lane_idx][ctl.step];
		gvalid    = ctl.step < STEP_W'(LANES);
		gi        = gvalid ? ctl.step[LANE_W-1:0] : '0;
		gd        = GAL_DEST[ctl.k][gi];
		own_dest  = {1'b0, lane_idx};
		fold_dest = (lane_idx < LANE_W'(3)) ? K_W'(lane_idx) + K_W'(LANES)
			: K_W'(lane_idx) + K_W'(3);
		if (ctl.galois) begin
			mac_a = acc[gi];
			mac_b = coef_t'(1);
			mac_v = gvalid && (gd == own_dest || gd == fold_dest);
			mac_n = gd == fold_dest;
		end else begin
			mac_a = acc[sc.ai];
			mac_b = opnd[sc.bj];
			mac_v = sc.valid;
			mac_n = sc.neg;
		end
		cur      = {rem_q, sh_q[WIDE_W-1 -: DIGIT_W]};
		dprod    = cur * CUR_W'(DIV3_RECIP);
		qd       = dprod[DIV3_SHIFT +: DIGIT_W];
		rnew     = cur - ({2'b00, qd} + {1'b0, qd, 1'b0});
		x_abs    = x_q[WIDE_W-1] ? -x_q : x_q;
		prod_ext = {{(WIDE_W-2*COEF_W){prod_s1[2*COEF_W-1]}}, prod_s1};
		a_own    = acc[lane_idx];
		b_own    = opnd[lane_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= (ctl.op == L_MAC) && mac_v;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mac_a * mac_b;
		pn_s1   <= mac_n;
		case (ctl.op)
			L_LOAD_B: begin
				x_q <= {{(WIDE_W-COEF_W){b_own[COEF_W-1]}}, b_own};
			end
			L_LOAD_XY: begin
				x_q <= {{(WIDE_W-COEF_W){a_own[COEF_W-1]}}, a_own};
				y_q <= {{(WIDE_W-COEF_W){b_own[COEF_W-1]}}, b_own};
			end
			L_X3:       x_q <= x_q + (x_q <<< 1);
			L_Y3:       y_q <= y_q + (y_q <<< 1);
			L_ADD:      x_q <= x_q + y_q;
			L_SUB:      x_q <= x_q - y_q;
			L_CLR:      x_q <= '0;
			L_TO_MAG: begin
				mag_q <= x_abs;
				sgn_q <= x_q[WIDE_W-1];
			end
			L_DIV_INIT: begin
				sh_q  <= mag_q;
				rem_q <= '0;
			end
			L_DIV_STEP: begin
				sh_q  <= sh_q << DIGIT_W;
				quo_q <= {quo_q[WIDE_W-DIGIT_W-1:0], qd};
				rem_q <= rnew[1:0];
			end
			L_DIV_TAKE: mag_q <= quo_q;
			L_MAC, L_HOLD: begin
				if (pv_s1) x_q <= pn_s1 ? x_q - prod_ext : x_q + prod_ext;
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.rem_zero = rem_q == 2'd0;
		sts.fits     = (mag_q[WIDE_W-1:COEF_W-1] == '0)
			|| (sgn_q && mag_q[WIDE_W-1:COEF_W] == '0 && mag_q[COEF_W-1]
			&& mag_q[COEF_W-2:0] == '0);
		sts.coef     = sgn_q ? coef_t'(-mag_q[COEF_W-1:0]) : coef_t'(mag_q[COEF_W-1:0]);
	end

endmodule

FILE: rtl/cnra_merge.sv
// merges the lane status words into the block-wide divisibility and range flags
// depends on cnra_pkg
module cnra_merge import cnra_pkg::*; (
	input  lane_sts_vec_t sts,
	output merge_t        mrg
);

	always_comb begin
		mrg.all_rem_zero = 1'b1;
		mrg.all_fit      = 1'b1;
		for (int i = 0; i < LANES; i++) begin
			mrg.all_rem_zero = mrg.all_rem_zero & sts[i].rem_zero;
			mrg.all_fit      = mrg.all_fit & sts[i].fits;
		end
	end

endmodule

FILE: rtl/cyclotomic_ninth_root_ring_alu.sv
// Accumulator ALU over Z[zeta_9, 1/3]. One operand transfer in, one result transfer out per
// item; a new operand is taken as soon as the previous result is stored, while it waits to be
// taken. Load needs no extra work; add and subtract first align the exponents by multiplying
// the side with the smaller exponent by three per step; multiply and Galois map run nine
// product steps on one 32x32 multiplier per lane, then a drain. Canonical form runs once on
// the operand and, except for unused codes, once on the result; it cancels factors of three
// while the exponent is nonzero and every lane divides evenly; each lane divides its 96-bit
// magnitude by three eight bits per cycle. Overflowing results leave the accumulator
// as it was.
// depends on cnra_pkg, cnra_lane, cnra_merge
module cyclotomic_ninth_root_ring_alu import cnra_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_stall,
	input  op_t  op,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	st_t              st_q;
	st_t              st_d;
	lane_ctl_t        ctl;
	lane_sts_vec_t    sts;
	merge_t           mrg;
	coef_vec_t        acc_q;
	logic [EXP_W-1:0] acc_exp_q;
	coef_vec_t        opnd_q;
	logic [2:0]       func_q;
	logic [K_W-1:0]   k_q;
	logic [EXP_W-1:0] bexp_q;
	logic [EXPI_W-1:0] exp_q;
	logic [EXP_W-1:0] xe_q;
	logic [EXP_W-1:0] ye_q;
	logic             phase_q;
	logic             nochg_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [STEP_W-1:0] step_q;
	logic             res_valid_q;
	res_t             res_q;
	logic             commit_go;
	logic             ovf;
	logic             upd;
	coef_vec_t        new_acc;
	logic             new_zero;
	logic [K_W-1:0]   k_in;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		cnra_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.lane_idx (LANE_W'(g)),
			.ctl      (ctl),
			.acc      (acc_q),
			.opnd     (opnd_q),
			.sts      (sts[g])
		);
	end

	cnra_merge u_merge (
		.sts (sts),
		.mrg (mrg)
	);

	assign op_stall  = st_q != ST_IDLE;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign commit_go = (st_q == ST_COMMIT) && (!res_valid_q || !res_stall);
	assign k_in      = (op.galois_k >= K_W'(ZETA_ORD)) ? op.galois_k - K_W'(ZETA_ORD)
		: op.galois_k;

	always_comb begin
		ovf      = !nochg_q && (exp_q > EXPI_W'(EXP_MAX) || !mrg.all_fit);
		upd      = !nochg_q && !ovf;
		new_zero = 1'b1;
		for (int i = 0; i < LANES; i++) begin
			new_acc[i] = upd ? sts[i].coef : acc_q[i];
			new_zero   = new_zero & (new_acc[i] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		ctl  = '{op: L_HOLD, galois: func_q == FN_GAL, step: step_q, k: k_q};
		unique case (st_q)
			ST_IDLE: begin
				if (op_valid) st_d = ST_BLOAD;
			end
			ST_BLOAD: begin
				ctl.op = L_LOAD_B;
				st_d   = ST_TOMAG;
			end
			ST_TOMAG: begin
				ctl.op = L_TO_MAG;
				st_d   = ST_CHECK;
			end
			ST_CHECK: begin
				if (exp_q == '0) begin
					st_d = phase_q ? ST_COMMIT : ST_BSAVE;
				end else begin
					ctl.op = L_DIV_INIT;
					st_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				ctl.op = L_DIV_STEP;
				if (dcnt_q == DCNT_W'(N_DIGITS - 1)) st_d = ST_DIVCHK;
			end
			ST_DIVCHK: begin
				if (mrg.all_rem_zero) begin
					ctl.op = L_DIV_TAKE;
					st_d   = ST_CHECK;
				end else begin
					st_d = phase_q ? ST_COMMIT : ST_BSAVE;
				end
			end
			ST_BSAVE: st_d = ST_DISPATCH;
			ST_DISPATCH: begin
				case (func_q) inside
					FN_LOAD: begin
						ctl.op = L_LOAD_B;
						st_d   = ST_TOMAG;
					end
					FN_ADD, FN_SUB: begin
						ctl.op = L_LOAD_XY;
						st_d   = ST_ALIGN;
					end
					FN_MUL, FN_GAL: begin
						ctl.op = L_CLR;
						st_d   = ST_MAC;
					end
					default: st_d = ST_COMMIT;
				endcase
			end
			ST_ALIGN: begin
				if (xe_q < ye_q) begin
					ctl.op = L_X3;
				end else if (ye_q < xe_q) begin
					ctl.op = L_Y3;
				end else begin
					ctl.op = (func_q == FN_ADD) ? L_ADD : L_SUB;
					st_d   = ST_TOMAG;
				end
			end
			ST_MAC: begin
				ctl.op = L_MAC;
				if (step_q == STEP_W'(MAC_STEPS - 1)) st_d = ST_DRAIN;
			end
			ST_DRAIN: st_d = ST_TOMAG;
			ST_COMMIT: begin
				if (commit_go) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (op_valid) begin
					opnd_q  <= {op.b_c5, op.b_c4, op.b_c3, op.b_c2, op.b_c1, op.b_c0};
					func_q  <= op.func;
					k_q     <= k_in;
					exp_q   <= {1'b0, op.b_exp};
					phase_q <= 1'b0;
					nochg_q <= 1'b0;
				end
			end
			ST_CHECK: dcnt_q <= '0;
			ST_DIV:   dcnt_q <= dcnt_q + 1'b1;
			ST_DIVCHK: begin
				if (mrg.all_rem_zero) exp_q <= exp_q - 1'b1;
			end
			ST_BSAVE: begin
				for (int i = 0; i < LANES; i++) opnd_q[i] <= sts[i].coef;
				bexp_q <= exp_q[EXP_W-1:0];
			end
			ST_DISPATCH: begin
				phase_q <= 1'b1;
				step_q  <= '0;
				xe_q    <= acc_exp_q;
				ye_q    <= bexp_q;
				case (func_q) inside
					FN_LOAD: exp_q <= {1'b0, bexp_q};
					FN_MUL:  exp_q <= {1'b0, acc_exp_q} + {1'b0, bexp_q};
					FN_GAL:  exp_q <= {1'b0, acc_exp_q};
					FN_ADD, FN_SUB: ;
					default: nochg_q <= 1'b1;
				endcase
			end
			ST_ALIGN: begin
				if (xe_q < ye_q) begin
					xe_q <= xe_q + 1'b1;
				end else if (ye_q < xe_q) begin
					ye_q <= ye_q + 1'b1;
				end else begin
					exp_q <= {1'b0, ye_q};
				end
			end
			ST_MAC: step_q <= step_q + 1'b1;
			ST_COMMIT: begin
				if (commit_go) begin
					res_q.r_c0     <= new_acc[0];
					res_q.r_c1     <= new_acc[1];
					res_q.r_c2     <= new_acc[2];
					res_q.r_c3     <= new_acc[3];
					res_q.r_c4     <= new_acc[4];
					res_q.r_c5     <= new_acc[5];
					res_q.r_exp    <= upd ? exp_q[EXP_W-1:0] : acc_exp_q;
					res_q.is_zero  <= new_zero;
					res_q.overflow <= ovf;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			acc_exp_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (commit_go) begin
				res_valid_q <= 1'b1;
				if (upd) begin
					acc_q     <= new_acc;
					acc_exp_q <= exp_q[EXP_W-1:0];
				end
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_zero_exp: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_zero |-> res.r_exp == '0)
		else $error("zero result with nonzero exponent");

	a_ovf_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		commit_go && ovf |=> acc_q == $past(acc_q) && acc_exp_q == $past(acc_exp_q))
		else $error("accumulator changed on overflow");

	a_res_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(st_q) == ST_COMMIT)
		else $error("result raised outside commit");

endmodule
